[hdl/bad_pkg.sv]
package bad_pkg;

	localparam int STAGES     = 16;
	localparam int COORD_BITS = 16;
	localparam int FIELD_W    = 16;
	localparam int PRESCALE   = 20;
	localparam int TABLE_LEN  = 24;
	localparam int NCELLS     = (STAGES < TABLE_LEN) ? STAGES : TABLE_LEN;
	localparam int IW         = $clog2(TABLE_LEN);

	// Difference width, and datapath width with room for the sign flip,
	// the prescale and the CORDIC gain of about 1.65 times root two.
	localparam int DW = COORD_BITS + 1;
	localparam int XW = COORD_BITS + 24;

	// Angle accumulator counts 1/65536 degree.
	localparam int ZW        = 27;
	localparam int TAB_W     = 22;
	localparam int OUT_SHIFT = 9;
	localparam int OUT_W     = 16;

	localparam logic signed [ZW-1:0] Z_HALF_TURN = ZW'(180 * 65536);
	localparam logic signed [ZW-1:0] Z_FULL_TURN = ZW'(360 * 65536);
	localparam logic signed [ZW-1:0] Z_ROUND     = ZW'(1 << (OUT_SHIFT - 1));
	localparam logic [OUT_W-1:0]     OUT_FULL    = OUT_W'(46080);

	// atan(2^-i) in degrees times 65536, rounded to nearest.
	localparam logic [TAB_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		22'd2949120, 22'd1740967, 22'd919879, 22'd466945,
		22'd234379,  22'd117304,  22'd58666,  22'd29335,
		22'd14668,   22'd7334,    22'd3667,   22'd1833,
		22'd917,     22'd458,     22'd229,    22'd115,
		22'd57,      22'd29,      22'd14,     22'd7,
		22'd4,       22'd2,       22'd1,      22'd0
	};

	typedef struct packed {
		logic                   zero;
		logic signed [XW-1:0]   x;
		logic signed [XW-1:0]   y;
		logic signed [ZW-1:0]   z;
	} bad_vec_t;

	// Keeps the low COORD_BITS bits of the field, sign-extended from the top one.
	function automatic logic signed [COORD_BITS-1:0] take_coord(
		input logic signed [FIELD_W-1:0] f
	);
		return COORD_BITS'(f);
	endfunction

endpackage

[hdl/bearing_angle_degrees.sv]
// Channel | Signals                            | Word
// input   | in_valid, in_ready                 | from_x, from_y, to_x, to_y (signed 16)
// output  | out_valid, out_ready               | angle (unsigned 16, 1/128 degree)
//
// One word is taken per cycle while no stall backs up to the input; the path holds
// a difference stage, one register per CORDIC cell, and the rounding stage.
// Every stage holds its own valid bit, so bubbles close up under a stall and
// in_ready drops only when all stages and the output register are full.
// Reset clears the valid bits only.
module bearing_angle_degrees (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            from_x,
	input  logic signed [15:0]            from_y,
	input  logic signed [15:0]            to_x,
	input  logic signed [15:0]            to_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [15:0]                   angle
);

	bad_pkg::bad_vec_t           node_vec [bad_pkg::NCELLS+1];
	logic [bad_pkg::NCELLS:0]    node_valid;
	logic [bad_pkg::NCELLS:0]    node_ready;

	bad_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.from_x    (from_x),
		.from_y    (from_y),
		.to_x      (to_x),
		.to_y      (to_y),
		.out_valid (node_valid[0]),
		.out_ready (node_ready[0]),
		.out_vec   (node_vec[0])
	);

	for (genvar i = 0; i < bad_pkg::NCELLS; i++) begin : g_cell
		bad_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (bad_pkg::IW'(i)),
			.in_valid  (node_valid[i]),
			.in_ready  (node_ready[i]),
			.in_vec    (node_vec[i]),
			.out_valid (node_valid[i+1]),
			.out_ready (node_ready[i+1]),
			.out_vec   (node_vec[i+1])
		);
	end

	bad_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (node_valid[bad_pkg::NCELLS]),
		.in_ready  (node_ready[bad_pkg::NCELLS]),
		.in_vec    (node_vec[bad_pkg::NCELLS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.angle     (angle)
	);

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle < bad_pkg::OUT_FULL)
		else $error("angle out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&node_valid) && out_valid && !out_ready)
		else $error("input stalled with a free stage");

	a_right_half: assert property (@(posedge clk) disable iff (!arst_n)
		node_valid[0] |-> !node_vec[0].x[bad_pkg::XW-1])
		else $error("vector not folded into right half plane");

endmodule

[hdl/bad_prep.sv]
module bad_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            from_x,
	input  logic signed [15:0]            from_y,
	input  logic signed [15:0]            to_x,
	input  logic signed [15:0]            to_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bad_pkg::bad_vec_t             out_vec
);

	logic signed [bad_pkg::DW-1:0] dx;
	logic signed [bad_pkg::DW-1:0] dy;
	logic signed [bad_pkg::DW:0]   dx_e;
	logic signed [bad_pkg::DW:0]   dy_e;
	logic signed [bad_pkg::DW:0]   mx;
	logic signed [bad_pkg::DW:0]   my;
	logic                          neg;
	bad_pkg::bad_vec_t             vec_d;
	bad_pkg::bad_vec_t             vec_s1;
	logic                          valid_s1;

	always_comb begin
		dx = bad_pkg::DW'(bad_pkg::take_coord(to_x)) - bad_pkg::DW'(bad_pkg::take_coord(from_x));
		dy = bad_pkg::DW'(bad_pkg::take_coord(to_y)) - bad_pkg::DW'(bad_pkg::take_coord(from_y));
		dx_e = (bad_pkg::DW + 1)'(dx);
		dy_e = (bad_pkg::DW + 1)'(dy);
		neg = dx[bad_pkg::DW-1];
		// The left half plane is folded over by negating the vector.
		mx = neg ? -dx_e : dx_e;
		my = neg ? -dy_e : dy_e;
		vec_d.zero = (dx == '0) && (dy == '0);
		vec_d.x = bad_pkg::XW'(mx) <<< bad_pkg::PRESCALE;
		vec_d.y = bad_pkg::XW'(my) <<< bad_pkg::PRESCALE;
		vec_d.z = neg ? bad_pkg::Z_HALF_TURN : '0;
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vec_s1 <= vec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

[hdl/bad_cell.sv]
module bad_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bad_pkg::IW-1:0]       idx,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  bad_pkg::bad_vec_t            in_vec,
	output logic                         out_valid,
	input  logic                         out_ready,
	output bad_pkg::bad_vec_t            out_vec
);

	logic signed [bad_pkg::XW-1:0] xs;
	logic signed [bad_pkg::XW-1:0] ys;
	logic signed [bad_pkg::ZW-1:0] step;
	bad_pkg::bad_vec_t             vec_d;
	bad_pkg::bad_vec_t             vec_s1;
	logic                          valid_s1;

	always_comb begin
		xs = in_vec.x >>> idx;
		ys = in_vec.y >>> idx;
		step = signed'(bad_pkg::ZW'(bad_pkg::ATAN_TAB[idx]));
		vec_d.zero = in_vec.zero;
		// Rotate towards the x axis; the sign of y picks the direction.
		if (in_vec.y[bad_pkg::XW-1]) begin
			vec_d.x = in_vec.x - ys;
			vec_d.y = in_vec.y + xs;
			vec_d.z = in_vec.z - step;
		end else begin
			vec_d.x = in_vec.x + ys;
			vec_d.y = in_vec.y - xs;
			vec_d.z = in_vec.z + step;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			vec_s1 <= vec_d;
		end
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

[hdl/bad_final.sv]
module bad_final (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  bad_pkg::bad_vec_t             in_vec,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bad_pkg::OUT_W-1:0]     angle
);

	logic signed [bad_pkg::ZW-1:0] z_fix;
	logic signed [bad_pkg::ZW-1:0] z_rnd;
	logic [bad_pkg::OUT_W-1:0]     r;
	logic [bad_pkg::OUT_W-1:0]     angle_d;
	logic [bad_pkg::OUT_W-1:0]     angle_s1;
	logic                          valid_s1;

	always_comb begin
		z_fix = in_vec.z[bad_pkg::ZW-1] ? in_vec.z + bad_pkg::Z_FULL_TURN : in_vec.z;
		z_rnd = z_fix + bad_pkg::Z_ROUND;
		r = z_rnd[bad_pkg::OUT_SHIFT +: bad_pkg::OUT_W];
		// A value that rounds up to a full turn wraps to zero.
		if (in_vec.zero) begin
			angle_d = '0;
		end else if (r >= bad_pkg::OUT_FULL) begin
			angle_d = r - bad_pkg::OUT_FULL;
		end else begin
			angle_d = r;
		end
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			angle_s1 <= angle_d;
		end
	end

	assign out_valid = valid_s1;
	assign angle     = angle_s1;

endmodule
